@@ hw/rtl/rrm_pkg.sv @@
package rrm_pkg;

  // input action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_COUNT = 2'd1;

  localparam logic [8:0]  FEATURE_LENGTH_RST  = 9'd256;
  localparam logic [10:0] REFERENCE_COUNT_RST = 11'd1024;

  localparam logic KIND_QUERY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [16:0] Q16_ONE       = 17'd65536;
  localparam logic [13:0] NO_MATCH_RANK = 14'd10000;

endpackage

@@ hw/rtl/rrm_ram.sv @@
module rrm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/retrieval_rank_metrics.sv @@
// Channel | Dir | Handshake           | Beat
// in      | in  | in_valid_i/in_stall_o   | action, slot, element, feature, label
// out     | out | out_valid_o/out_stall_i | per-query stats or batch summary
// cfg     | in  | cfg_valid_i/cfg_ready_o | register index and data
//
// Load beats and non-final query beats: one per cycle while in_stall_o is low.
// Final query beat: scores all N refs over L elements, ranks them, then walks the H hits,
// with one shared divide per hit and three more for the query stats when H is not zero.
// Finish beat: ranks the B batch queries for the median, then four shared divides (none if B is 0).
// Async active-low reset clears control, sums and counter and sets config to its defaults; RAMs are not cleared.
// in_stall_o is high while a query or finish is worked; a held result does not block loads.
module retrieval_rank_metrics #(
  parameter int MAX_REFS  = 1024,
  parameter int MAX_DIM   = 256,
  parameter int MAX_BATCH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [9:0]                    ref_slot_i,
  input  logic [7:0]                    element_index_i,
  input  logic signed [15:0]            feature_i,
  input  logic [15:0]                   label_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [13:0]                   best_rank_o,
  output logic [14:0]                   median_rank_twice_o,
  output logic [16:0]                   avg_precision_o,
  output logic [16:0]                   recall_1_o,
  output logic [16:0]                   recall_5_o,
  output logic [16:0]                   recall_10_o,
  output logic [8:0]                    queries_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rrm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rrm_pkg::*;

  localparam int CW   = $clog2(MAX_REFS + 1);
  localparam int BW   = $clog2(MAX_BATCH + 1);
  localparam int EW   = $clog2(MAX_DIM + 1);
  localparam int XW   = (CW > BW) ? CW : BW;
  localparam int RAW  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int DAW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int BAW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int FDEP = MAX_REFS * MAX_DIM;
  localparam int FAW  = (FDEP > 1) ? $clog2(FDEP) : 1;
  localparam int SCW  = 33 + $clog2(MAX_DIM);
  localparam int ACW  = SCW - 1;
  localparam int NUMW = XW + 17;
  localparam int NW   = NUMW + 2;
  localparam int DW   = XW + 1;
  localparam int DCW  = $clog2(NW + 1);
  localparam int SW   = BW + 17;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_DOT     = 5'd1;
  localparam logic [4:0] ST_RK_LD   = 5'd2;
  localparam logic [4:0] ST_RK_HOLD = 5'd3;
  localparam logic [4:0] ST_RK_SCAN = 5'd4;
  localparam logic [4:0] ST_RK_WR   = 5'd5;
  localparam logic [4:0] ST_WK_RD   = 5'd6;
  localparam logic [4:0] ST_WK_CHK  = 5'd7;
  localparam logic [4:0] ST_WDIV    = 5'd8;
  localparam logic [4:0] ST_WDIV_W  = 5'd9;
  localparam logic [4:0] ST_QPOST   = 5'd10;
  localparam logic [4:0] ST_QDIV    = 5'd11;
  localparam logic [4:0] ST_QDIV_W  = 5'd12;
  localparam logic [4:0] ST_QUPD    = 5'd13;
  localparam logic [4:0] ST_QOUT    = 5'd14;
  localparam logic [4:0] ST_FIN     = 5'd15;
  localparam logic [4:0] ST_FDIV    = 5'd16;
  localparam logic [4:0] ST_FDIV_W  = 5'd17;
  localparam logic [4:0] ST_FOUT    = 5'd18;

  // control registers
  logic [4:0]     state_q, state_d;
  logic [8:0]     flen_q, flen_d;
  logic [10:0]    nref_q, nref_d;
  logic [15:0]    qlabel_q, qlabel_d;
  logic [BW-1:0]  qc_q, qc_d;
  logic [SW-1:0]  sums_q [4];
  logic [SW-1:0]  sums_d [4];
  logic           mode_q, mode_d;
  logic [XW-1:0]  i_q, i_d, j_q, j_d, cnt_q, cnt_d, pos_q, pos_d, hits_q, hits_d;
  logic [EW-1:0]  e_q, e_d;
  logic           iss_done_q, iss_done_d;
  logic           d1_v_q, d1_v_d, d2_v_q, d2_v_d, sv_q, sv_d;
  logic [1:0]     jb_q, jb_d;
  logic           div_busy_q, div_busy_d;
  logic [DCW-1:0] div_cnt_q, div_cnt_d;
  logic           out_v_q, out_v_d;

  // datapath registers
  logic           d1_first_q, d1_first_d, d1_last_q, d1_last_d;
  logic           d2_first_q, d2_first_d, d2_last_q, d2_last_d;
  logic [XW-1:0]  d1_r_q, d1_r_d, d2_r_q, d2_r_d, sj_q, sj_d;
  logic signed [31:0]     prod_q, prod_d;
  logic signed [ACW-1:0]  acc_q, acc_d;
  logic signed [SCW-1:0]  key_i_q, key_i_d;
  logic           match_i_q, match_i_d;
  logic [13:0]    best_q, best_d, m1_q, m1_d, m2_q, m2_d;
  logic           h1_q, h1_d;
  logic [2:0]     h5_q, h5_d;
  logic [3:0]     h10_q, h10_d;
  logic [NUMW-1:0] psum_q, psum_d;
  logic [16:0]    res_q [4];
  logic [16:0]    res_d [4];
  logic [NW-1:0]  div_n_q, div_n_d, div_quo_q, div_quo_d;
  logic [DW-1:0]  div_d_q, div_d_d, div_rem_q, div_rem_d;
  logic           out_kind_q, out_kind_d;
  logic [13:0]    out_best_q, out_best_d;
  logic [14:0]    out_med_q, out_med_d;
  logic [16:0]    out_ap_q, out_ap_d, out_r1_q, out_r1_d, out_r5_q, out_r5_d;
  logic [16:0]    out_r10_q, out_r10_d;
  logic [8:0]     out_qd_q, out_qd_d;

  // memory ports
  logic            feat_we, lab_we, qry_we, score_we, hit_we, bat_we;
  logic [FAW-1:0]  feat_waddr, feat_raddr;
  logic [RAW-1:0]  lab_raddr, score_waddr, score_raddr, hit_waddr, hit_raddr;
  logic [DAW-1:0]  qry_waddr;
  logic [BAW-1:0]  bat_raddr;
  logic [15:0]     feat_rdata, lab_rdata, qry_rdata;
  logic [SCW-1:0]  score_wdata, score_rdata;
  logic            hit_wdata, hit_rdata;
  logic [13:0]     bat_rdata;

  // misc
  logic            in_acc, can_load, issue, scan_issue, lt, query_last;
  logic [EW-1:0]   len_eff;
  logic [XW-1:0]   nref_eff, n_last;
  logic signed [ACW-1:0] acc_sum;
  logic signed [SCW-1:0] key_rd;
  logic            div_start;
  logic [NUMW-1:0] div_num;
  logic [XW-1:0]   div_den;
  logic [DW:0]     rem_sh;
  logic [16:0]     div_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign can_load    = !out_v_q || !out_stall_i;
  assign div_res     = div_quo_q[16:0];

  always_comb begin
    if (flen_q == '0) begin
      len_eff = EW'(1);
    end else if (32'(flen_q) > MAX_DIM) begin
      len_eff = EW'(MAX_DIM);
    end else begin
      len_eff = EW'(flen_q);
    end
    if (nref_q == '0) begin
      nref_eff = XW'(1);
    end else if (32'(nref_q) > MAX_REFS) begin
      nref_eff = XW'(MAX_REFS);
    end else begin
      nref_eff = XW'(nref_q);
    end
  end

  assign n_last     = (mode_q ? XW'(qc_q) : nref_eff) - XW'(1);
  assign query_last = (32'(element_index_i) + 1 == 32'(len_eff));

  // input side writes
  assign feat_we    = in_acc && (action_i == ACT_LOAD) && (32'(ref_slot_i) < MAX_REFS)
                      && (32'(element_index_i) < MAX_DIM);
  assign feat_waddr = FAW'(32'(ref_slot_i) * MAX_DIM + 32'(element_index_i));
  assign lab_we     = in_acc && (action_i == ACT_LOAD) && (32'(ref_slot_i) < MAX_REFS);
  assign qry_we     = in_acc && (action_i == ACT_QUERY) && (32'(element_index_i) < MAX_DIM);
  assign qry_waddr  = DAW'(element_index_i);

  // dot product issue addresses
  assign issue       = (state_q == ST_DOT) && !iss_done_q;
  assign feat_raddr  = FAW'(32'(i_q) * MAX_DIM + 32'(e_q));
  assign acc_sum     = (d2_first_q ? '0 : acc_q) - ACW'(prod_q);
  assign score_we    = d2_v_q && d2_last_q;
  assign score_waddr = d2_r_q[RAW-1:0];
  assign score_wdata = {acc_sum, 1'b0};

  // rank pass
  assign scan_issue  = (state_q == ST_RK_SCAN) && !iss_done_q;
  assign score_raddr = (state_q == ST_RK_SCAN) ? j_q[RAW-1:0] : i_q[RAW-1:0];
  assign bat_raddr   = (state_q == ST_RK_SCAN) ? j_q[BAW-1:0] : i_q[BAW-1:0];
  assign lab_raddr   = i_q[RAW-1:0];
  assign key_rd      = mode_q ? $signed({{(SCW-14){1'b0}}, bat_rdata}) : $signed(score_rdata);
  assign lt          = (key_rd < key_i_q) || ((key_rd == key_i_q) && (sj_q < i_q));
  assign hit_we      = (state_q == ST_RK_WR) && !mode_q;
  assign hit_waddr   = cnt_q[RAW-1:0];
  assign hit_wdata   = match_i_q;
  assign hit_raddr   = pos_q[RAW-1:0];
  assign bat_we      = (state_q == ST_QUPD) && (32'(qc_q) < MAX_BATCH);

  // shared divider operand select: round(num/den) = floor((2num+den)/(2den))
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = XW'(1);
    priority case (state_q)
      ST_WDIV: begin
        div_start = 1'b1;
        div_num   = NUMW'({hits_q, 16'b0});
        div_den   = pos_q + XW'(1);
      end
      ST_QDIV: begin
        div_start = 1'b1;
        priority case (jb_q)
          2'd0: begin
            div_num = psum_q;
            div_den = hits_q;
          end
          2'd1: begin
            div_num = NUMW'({h5_q, 16'b0});
            div_den = (32'(hits_q) < 5) ? hits_q : XW'(5);
          end
          default: begin
            div_num = NUMW'({h10_q, 16'b0});
            div_den = (32'(hits_q) < 10) ? hits_q : XW'(10);
          end
        endcase
      end
      ST_FDIV: begin
        div_start = 1'b1;
        div_num   = NUMW'(sums_q[jb_q]);
        div_den   = XW'(qc_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    rem_sh     = {div_rem_q, div_n_q[NW-1]};
    div_busy_d = div_busy_q;
    div_cnt_d  = div_cnt_q;
    div_n_d    = div_n_q;
    div_d_d    = div_d_q;
    div_rem_d  = div_rem_q;
    div_quo_d  = div_quo_q;
    if (div_start) begin
      div_n_d    = NW'({div_num, 1'b0}) + NW'(div_den);
      div_d_d    = {div_den, 1'b0};
      div_rem_d  = '0;
      div_quo_d  = '0;
      div_cnt_d  = DCW'(NW);
      div_busy_d = 1'b1;
    end else if (div_busy_q) begin
      div_n_d   = div_n_q << 1;
      div_cnt_d = div_cnt_q - DCW'(1);
      if (rem_sh >= {1'b0, div_d_q}) begin
        div_rem_d = DW'(rem_sh - {1'b0, div_d_q});
        div_quo_d = {div_quo_q[NW-2:0], 1'b1};
      end else begin
        div_rem_d = rem_sh[DW-1:0];
        div_quo_d = {div_quo_q[NW-2:0], 1'b0};
      end
      if (div_cnt_q == DCW'(1)) begin
        div_busy_d = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    flen_d     = flen_q;
    nref_d     = nref_q;
    qlabel_d   = qlabel_q;
    qc_d       = qc_q;
    sums_d     = sums_q;
    mode_d     = mode_q;
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    hits_d     = hits_q;
    e_d        = e_q;
    iss_done_d = iss_done_q;
    jb_d       = jb_q;
    key_i_d    = key_i_q;
    match_i_d  = match_i_q;
    best_d     = best_q;
    m1_d       = m1_q;
    m2_d       = m2_q;
    h1_d       = h1_q;
    h5_d       = h5_q;
    h10_d      = h10_q;
    psum_d     = psum_q;
    res_d      = res_q;
    acc_d      = acc_q;
    out_v_d    = out_v_q;
    out_kind_d = out_kind_q;
    out_best_d = out_best_q;
    out_med_d  = out_med_q;
    out_ap_d   = out_ap_q;
    out_r1_d   = out_r1_q;
    out_r5_d   = out_r5_q;
    out_r10_d  = out_r10_q;
    out_qd_d   = out_qd_q;

    // dot pipeline: read, multiply, accumulate
    d1_v_d     = issue;
    d1_first_d = (e_q == '0);
    d1_last_d  = (e_q == len_eff - EW'(1));
    d1_r_d     = i_q;
    d2_v_d     = d1_v_q;
    d2_first_d = d1_first_q;
    d2_last_d  = d1_last_q;
    d2_r_d     = d1_r_q;
    prod_d     = $signed(feat_rdata) * $signed(qry_rdata);
    sv_d       = scan_issue;
    sj_d       = j_q;
    if (d2_v_q) begin
      acc_d = acc_sum;
    end

    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FEATURE_LENGTH:  flen_d = cfg_data_i[8:0];
        CFG_REFERENCE_COUNT: nref_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_i == ACT_QUERY)) begin
          qlabel_d = label_i;
          if (query_last) begin
            mode_d     = 1'b0;
            i_d        = '0;
            e_d        = '0;
            iss_done_d = 1'b0;
            state_d    = ST_DOT;
          end
        end else if (in_acc && (action_i == ACT_FINISH)) begin
          state_d = ST_FIN;
        end
      end
      ST_DOT: begin
        if (issue) begin
          if (e_q == len_eff - EW'(1)) begin
            e_d = '0;
            if (i_q == n_last) begin
              iss_done_d = 1'b1;
            end else begin
              i_d = i_q + XW'(1);
            end
          end else begin
            e_d = e_q + EW'(1);
          end
        end
        if (d2_v_q && d2_last_q && (d2_r_q == n_last)) begin
          i_d     = '0;
          state_d = ST_RK_LD;
        end
      end
      ST_RK_LD: state_d = ST_RK_HOLD;
      ST_RK_HOLD: begin
        key_i_d    = key_rd;
        match_i_d  = (lab_rdata == qlabel_q);
        j_d        = '0;
        cnt_d      = '0;
        iss_done_d = 1'b0;
        state_d    = ST_RK_SCAN;
      end
      ST_RK_SCAN: begin
        if (scan_issue) begin
          if (j_q == n_last) begin
            iss_done_d = 1'b1;
          end else begin
            j_d = j_q + XW'(1);
          end
        end
        if (sv_q) begin
          cnt_d = cnt_q + XW'(lt);
          if (sj_q == n_last) begin
            state_d = ST_RK_WR;
          end
        end
      end
      ST_RK_WR: begin
        // batch mode: pick the two middle order statistics
        if (mode_q) begin
          if (cnt_q == (n_last >> 1)) begin
            m1_d = key_i_q[13:0];
          end
          if (cnt_q == ((n_last + XW'(1)) >> 1)) begin
            m2_d = key_i_q[13:0];
          end
        end
        if (i_q == n_last) begin
          if (mode_q) begin
            jb_d    = '0;
            state_d = ST_FDIV;
          end else begin
            pos_d   = '0;
            hits_d  = '0;
            best_d  = NO_MATCH_RANK;
            h1_d    = 1'b0;
            h5_d    = '0;
            h10_d   = '0;
            psum_d  = '0;
            state_d = ST_WK_RD;
          end
        end else begin
          i_d     = i_q + XW'(1);
          state_d = ST_RK_LD;
        end
      end
      ST_WK_RD: state_d = ST_WK_CHK;
      ST_WK_CHK: begin
        if (hit_rdata) begin
          hits_d = hits_q + XW'(1);
          if (32'(pos_q) + 1 < 32'(best_q)) begin
            best_d = 14'(32'(pos_q) + 1);
          end
          if (pos_q == '0) begin
            h1_d = 1'b1;
          end
          if (32'(pos_q) < 5) begin
            h5_d = h5_q + 3'd1;
          end
          if (32'(pos_q) < 10) begin
            h10_d = h10_q + 4'd1;
          end
          state_d = ST_WDIV;
        end else if (pos_q == n_last) begin
          state_d = ST_QPOST;
        end else begin
          pos_d   = pos_q + XW'(1);
          state_d = ST_WK_RD;
        end
      end
      ST_WDIV: state_d = ST_WDIV_W;
      ST_WDIV_W: begin
        if (!div_busy_q) begin
          psum_d = psum_q + NUMW'(div_res);
          if (pos_q == n_last) begin
            state_d = ST_QPOST;
          end else begin
            pos_d   = pos_q + XW'(1);
            state_d = ST_WK_RD;
          end
        end
      end
      ST_QPOST: begin
        res_d[0] = '0;
        res_d[1] = h1_q ? Q16_ONE : '0;
        res_d[2] = '0;
        res_d[3] = '0;
        jb_d     = '0;
        state_d  = (hits_q == '0) ? ST_QUPD : ST_QDIV;
      end
      ST_QDIV: state_d = ST_QDIV_W;
      ST_QDIV_W: begin
        if (!div_busy_q) begin
          // jobs: ap, recall 5, recall 10 into slots 0, 2, 3
          if (jb_q == '0) begin
            res_d[0] = div_res;
          end else begin
            res_d[jb_q + 2'd1] = div_res;
          end
          if (jb_q == 2'd2) begin
            state_d = ST_QUPD;
          end else begin
            jb_d    = jb_q + 2'd1;
            state_d = ST_QDIV;
          end
        end
      end
      ST_QUPD: begin
        if (32'(qc_q) < MAX_BATCH) begin
          for (int k = 0; k < 4; k++) begin
            sums_d[k] = sums_q[k] + SW'(res_q[k]);
          end
          qc_d = qc_q + BW'(1);
        end
        state_d = ST_QOUT;
      end
      ST_QOUT: begin
        if (can_load) begin
          out_v_d    = 1'b1;
          out_kind_d = KIND_QUERY;
          out_best_d = best_q;
          out_med_d  = '0;
          out_ap_d   = res_q[0];
          out_r1_d   = res_q[1];
          out_r5_d   = res_q[2];
          out_r10_d  = res_q[3];
          out_qd_d   = 9'(qc_q);
          state_d    = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (qc_q == '0) begin
          for (int k = 0; k < 4; k++) begin
            res_d[k] = '0;
          end
          m1_d    = '0;
          m2_d    = '0;
          state_d = ST_FOUT;
        end else begin
          mode_d  = 1'b1;
          i_d     = '0;
          state_d = ST_RK_LD;
        end
      end
      ST_FDIV: state_d = ST_FDIV_W;
      ST_FDIV_W: begin
        if (!div_busy_q) begin
          res_d[jb_q] = div_res;
          if (jb_q == 2'd3) begin
            state_d = ST_FOUT;
          end else begin
            jb_d    = jb_q + 2'd1;
            state_d = ST_FDIV;
          end
        end
      end
      ST_FOUT: begin
        if (can_load) begin
          out_v_d    = 1'b1;
          out_kind_d = KIND_SUMMARY;
          out_best_d = '0;
          out_med_d  = 15'(m1_q) + 15'(m2_q);
          out_ap_d   = res_q[0];
          out_r1_d   = res_q[1];
          out_r5_d   = res_q[2];
          out_r10_d  = res_q[3];
          out_qd_d   = 9'(qc_q);
          for (int k = 0; k < 4; k++) begin
            sums_d[k] = '0;
          end
          qc_d    = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      flen_q     <= FEATURE_LENGTH_RST;
      nref_q     <= REFERENCE_COUNT_RST;
      qlabel_q   <= '0;
      qc_q       <= '0;
      for (int k = 0; k < 4; k++) begin
        sums_q[k] <= '0;
      end
      mode_q     <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      cnt_q      <= '0;
      pos_q      <= '0;
      hits_q     <= '0;
      e_q        <= '0;
      iss_done_q <= 1'b0;
      d1_v_q     <= 1'b0;
      d2_v_q     <= 1'b0;
      sv_q       <= 1'b0;
      jb_q       <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      flen_q     <= flen_d;
      nref_q     <= nref_d;
      qlabel_q   <= qlabel_d;
      qc_q       <= qc_d;
      sums_q     <= sums_d;
      mode_q     <= mode_d;
      i_q        <= i_d;
      j_q        <= j_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      hits_q     <= hits_d;
      e_q        <= e_d;
      iss_done_q <= iss_done_d;
      d1_v_q     <= d1_v_d;
      d2_v_q     <= d2_v_d;
      sv_q       <= sv_d;
      jb_q       <= jb_d;
      div_busy_q <= div_busy_d;
      div_cnt_q  <= div_cnt_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_first_q <= d1_first_d;
    d1_last_q  <= d1_last_d;
    d1_r_q     <= d1_r_d;
    d2_first_q <= d2_first_d;
    d2_last_q  <= d2_last_d;
    d2_r_q     <= d2_r_d;
    sj_q       <= sj_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    key_i_q    <= key_i_d;
    match_i_q  <= match_i_d;
    best_q     <= best_d;
    m1_q       <= m1_d;
    m2_q       <= m2_d;
    h1_q       <= h1_d;
    h5_q       <= h5_d;
    h10_q      <= h10_d;
    psum_q     <= psum_d;
    res_q      <= res_d;
    div_n_q    <= div_n_d;
    div_d_q    <= div_d_d;
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    out_kind_q <= out_kind_d;
    out_best_q <= out_best_d;
    out_med_q  <= out_med_d;
    out_ap_q   <= out_ap_d;
    out_r1_q   <= out_r1_d;
    out_r5_q   <= out_r5_d;
    out_r10_q  <= out_r10_d;
    out_qd_q   <= out_qd_d;
  end

  assign out_valid_o         = out_v_q;
  assign kind_o              = out_kind_q;
  assign best_rank_o         = out_best_q;
  assign median_rank_twice_o = out_med_q;
  assign avg_precision_o     = out_ap_q;
  assign recall_1_o          = out_r1_q;
  assign recall_5_o          = out_r5_q;
  assign recall_10_o         = out_r10_q;
  assign queries_done_o      = out_qd_q;

  rrm_ram #(.Width(16), .Depth(FDEP)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (feat_waddr),
    .wdata_i (feature_i),
    .raddr_i (feat_raddr),
    .rdata_o (feat_rdata)
  );

  rrm_ram #(.Width(16), .Depth(MAX_REFS)) u_lab_ram (
    .clk_i   (clk_i),
    .we_i    (lab_we),
    .waddr_i (ref_slot_i[RAW-1:0]),
    .wdata_i (label_i),
    .raddr_i (lab_raddr),
    .rdata_o (lab_rdata)
  );

  rrm_ram #(.Width(16), .Depth(MAX_DIM)) u_qry_ram (
    .clk_i   (clk_i),
    .we_i    (qry_we),
    .waddr_i (qry_waddr),
    .wdata_i (feature_i),
    .raddr_i (e_q[DAW-1:0]),
    .rdata_o (qry_rdata)
  );

  rrm_ram #(.Width(SCW), .Depth(MAX_REFS)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (score_we),
    .waddr_i (score_waddr),
    .wdata_i (score_wdata),
    .raddr_i (score_raddr),
    .rdata_o (score_rdata)
  );

  rrm_ram #(.Width(1), .Depth(MAX_REFS)) u_hit_ram (
    .clk_i   (clk_i),
    .we_i    (hit_we),
    .waddr_i (hit_waddr),
    .wdata_i (hit_wdata),
    .raddr_i (hit_raddr),
    .rdata_o (hit_rdata)
  );

  rrm_ram #(.Width(14), .Depth(MAX_BATCH)) u_bat_ram (
    .clk_i   (clk_i),
    .we_i    (bat_we),
    .waddr_i (qc_q[BAW-1:0]),
    .wdata_i (best_q),
    .raddr_i (bat_raddr),
    .rdata_o (bat_rdata)
  );

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy_q)
    else $error("divider restarted while busy");

  a_query_starts_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i == ACT_QUERY) && query_last) |=> (state_q == ST_DOT))
    else $error("final query beat did not start scoring");

  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(qc_q) <= MAX_BATCH)
    else $error("batch counter overran");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic        kind;
    logic [13:0] best;
    logic [14:0] med2;
    logic [16:0] ap;
    logic [16:0] r1;
    logic [16:0] r5;
    logic [16:0] r10;
    logic [8:0]  qdone;
  } stats_t;

  typedef struct {
    logic [1:0]  act;
    logic [9:0]  slot;
    logic [7:0]  elem;
    logic [15:0] feat;
    logic [15:0] lab;
    bit          typed;
    stats_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] action = '0;
  logic [9:0] ref_slot = '0;
  logic [7:0] element_index = '0;
  logic signed [15:0] feature = '0;
  logic [15:0] label = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  logic kind;
  logic [13:0] best_rank;
  logic [14:0] median_rank_twice;
  logic [16:0] avg_precision, recall_1, recall_5, recall_10;
  logic [8:0] queries_done;

  retrieval_rank_metrics uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .ref_slot_i(ref_slot), .element_index_i(element_index),
    .feature_i(feature), .label_i(label),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .best_rank_o(best_rank), .median_rank_twice_o(median_rank_twice),
    .avg_precision_o(avg_precision), .recall_1_o(recall_1), .recall_5_o(recall_5),
    .recall_10_o(recall_10), .queries_done_o(queries_done),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ranking model state
  logic [15:0] ref_feat [0:1023][0:255];
  logic [15:0] ref_lab [0:1023];
  logic [15:0] query_vec [0:255];
  bit          query_written [0:255];
  logic [15:0] query_label = '0;
  int unsigned batch_rank [0:255];
  longint unsigned metric_sum [0:3];
  int unsigned batch_count = 0;
  int unsigned len_reg = FEATURE_LENGTH_RST;
  int unsigned refs_reg = REFERENCE_COUNT_RST;
  longint score [0:1023];
  int unsigned order [0:1023];

  stats_t pending_stats[$];
  bit failed = 1'b0;
  int tx_idle = 0;
  int rx_stall = 0;
  int rx_hold = 0;
  int unsigned cycles = 0;

  function automatic int unsigned cur_len();
    if (len_reg < 1) return 1;
    return (len_reg > 256) ? 256 : len_reg;
  endfunction

  function automatic int unsigned cur_refs();
    if (refs_reg < 1) return 1;
    return (refs_reg > 1024) ? 1024 : refs_reg;
  endfunction

  function automatic longint unsigned rnd_div(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic stats_t score_query();
    int unsigned len, nref, hits, h1, h5, h10, best, pos, cur;
    int j;
    longint dot;
    longint unsigned psum;
    stats_t s;
    len = cur_len();
    nref = cur_refs();
    hits = 0; h1 = 0; h5 = 0; h10 = 0; best = NO_MATCH_RANK; psum = 0;
    s = '0;
    for (int r = 0; r < nref; r++) begin
      dot = 0;
      for (int e = 0; e < len; e++)
        dot += longint'($signed(query_vec[e])) * longint'($signed(ref_feat[r][e]));
      score[r] = -2 * dot;
    end
    // stable insertion: ties keep lower index first
    for (int i = 0; i < nref; i++) begin
      cur = i;
      j = i;
      while (j > 0 && score[order[j-1]] > score[cur]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int r = 0; r < nref; r++) begin
      pos = r + 1;
      if (ref_lab[order[r]] == query_label) begin
        if (pos < best) best = pos;
        if (pos <= 1) h1++;
        if (pos <= 5) h5++;
        if (pos <= 10) h10++;
        hits++;
        psum += rnd_div(longint'(hits) * 65536, pos);
      end
    end
    if (hits > 0) begin
      s.ap = rnd_div(psum, hits);
      s.r1 = h1 ? Q16_ONE : '0;
      s.r5 = rnd_div(longint'(h5) * 65536, (hits < 5) ? hits : 5);
      s.r10 = rnd_div(longint'(h10) * 65536, (hits < 10) ? hits : 10);
    end
    if (batch_count < 256) begin
      batch_rank[batch_count] = best;
      metric_sum[0] += s.ap;
      metric_sum[1] += s.r1;
      metric_sum[2] += s.r5;
      metric_sum[3] += s.r10;
      batch_count++;
    end
    s.kind = KIND_QUERY;
    s.best = best;
    s.qdone = batch_count;
    return s;
  endfunction

  function automatic stats_t close_batch();
    int unsigned sorted [$];
    int unsigned n;
    stats_t s;
    n = batch_count;
    s = '0;
    s.kind = KIND_SUMMARY;
    if (n > 0) begin
      for (int i = 0; i < n; i++) sorted.push_back(batch_rank[i]);
      sorted.sort();
      s.med2 = (n % 2 == 0) ? sorted[n/2-1] + sorted[n/2] : 2 * sorted[n/2];
      s.ap = rnd_div(metric_sum[0], n);
      s.r1 = rnd_div(metric_sum[1], n);
      s.r5 = rnd_div(metric_sum[2], n);
      s.r10 = rnd_div(metric_sum[3], n);
    end
    s.qdone = n;
    for (int i = 0; i < 4; i++) metric_sum[i] = 0;
    batch_count = 0;
    return s;
  endfunction

  // apply one accepted beat to the model; returns 1 when a result is due
  function automatic bit rank_step(stim_row_t b, output stats_t s);
    s = '0;
    case (b.act)
      ACT_LOAD: begin
        ref_lab[b.slot] = b.lab;
        ref_feat[b.slot][b.elem] = b.feat;
        return 1'b0;
      end
      ACT_QUERY: begin
        query_vec[b.elem] = b.feat;
        query_written[b.elem] = 1'b1;
        query_label = b.lab;
        if (b.elem + 1 == cur_len()) begin
          s = score_query();
          return 1'b1;
        end
        return 1'b0;
      end
      ACT_FINISH: begin
        s = close_batch();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t beat(logic [1:0] a, logic [9:0] sl, logic [7:0] el,
                                     logic [15:0] f, logic [15:0] lb);
    stim_row_t b;
    b.act = a; b.slot = sl; b.elem = el; b.feat = f; b.lab = lb;
    b.typed = 1'b0; b.want = '0;
    return b;
  endfunction

  function automatic stim_row_t typed_beat(stim_row_t b, logic k, logic [13:0] br,
                                           logic [8:0] qd);
    b.typed = 1'b1;
    b.want = '0;
    b.want.kind = k;
    b.want.best = br;
    b.want.qdone = qd;
    return b;
  endfunction

  task automatic send(stim_row_t b);
    stats_t s;
    if ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle);
    end
    action <= b.act; ref_slot <= b.slot; element_index <= b.elem;
    feature <= b.feat; label <= b.lab;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (rank_step(b, s)) pending_stats.push_back(b.typed ? b.want : s);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FEATURE_LENGTH) len_reg = val & 9'h1FF;
    else if (idx == CFG_REFERENCE_COUNT) refs_reg = val & 11'h7FF;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_feat();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rnd_label();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom;
  endfunction

  task automatic load_refs();
    logic [15:0] lb;
    for (int r = 0; r < cur_refs(); r++) begin
      lb = rnd_label();
      for (int e = 0; e < cur_len(); e++)
        send(beat(ACT_LOAD, r, e, rnd_feat(), lb));
    end
  endtask

  task automatic full_query(logic [15:0] lb, bit zero_vec);
    for (int e = 0; e < cur_len(); e++)
      send(beat(ACT_QUERY, 0, e, zero_vec ? 16'h0 : rnd_feat(), lb));
  endtask

  task automatic random_phase(int unsigned len, int unsigned nref, int beats);
    int unsigned pick, el;
    drain();
    cfg_write(CFG_FEATURE_LENGTH, len);
    cfg_write(CFG_REFERENCE_COUNT, nref);
    load_refs();
    for (int i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        full_query(rnd_label(), 1'b0);
        i += cur_len() - 1;
      end else if (pick < 80) begin
        send(beat(ACT_LOAD, $urandom_range(0, cur_refs() - 1), $urandom_range(0, cur_len() - 1),
                  rnd_feat(), rnd_label()));
      end else if (pick < 86) begin
        send(beat(ACT_LOAD, $urandom, $urandom, $urandom, $urandom));
      end else if (pick < 91) begin
        // stray element that cannot complete the query
        el = (cur_len() + $urandom_range(0, 254)) % 256;
        send(beat(ACT_QUERY, $urandom, el, $urandom, $urandom));
      end else if (pick < 95) begin
        send(beat(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom));
      end else begin
        send(beat(ACT_FINISH, $urandom, $urandom, $urandom, $urandom));
      end
    end
    send(beat(ACT_FINISH, 0, 0, 0, 0));
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall);
    end
  end

  always @(posedge clk) begin
    stats_t want, got;
    if (out_valid && !out_stall) begin
      got = {kind, best_rank, median_rank_twice, avg_precision, recall_1, recall_5,
             recall_10, queries_done};
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_stats.pop_front();
        if (got.kind !== want.kind)
          $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
        if (got.best !== want.best)
          $display("%0t: best_rank exp %0d got %0d", $time, want.best, got.best);
        if (got.med2 !== want.med2)
          $display("%0t: median_rank_twice exp %0d got %0d", $time, want.med2, got.med2);
        if (got.ap !== want.ap)
          $display("%0t: avg_precision exp %0d got %0d", $time, want.ap, got.ap);
        if (got.r1 !== want.r1)
          $display("%0t: recall_1 exp %0d got %0d", $time, want.r1, got.r1);
        if (got.r5 !== want.r5)
          $display("%0t: recall_5 exp %0d got %0d", $time, want.r5, got.r5);
        if (got.r10 !== want.r10)
          $display("%0t: recall_10 exp %0d got %0d", $time, want.r10, got.r10);
        if (got.qdone !== want.qdone)
          $display("%0t: queries_done exp %0d got %0d", $time, want.qdone, got.qdone);
        if (got !== want) failed = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    for (int i = 0; i < 4; i++) metric_sum[i] = 0;
    for (int i = 0; i < 256; i++) query_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two elements, three references with extreme and tied scores
    cfg_write(CFG_FEATURE_LENGTH, 2);
    cfg_write(CFG_REFERENCE_COUNT, 3);
    rows.push_back(typed_beat(beat(ACT_FINISH, 0, 0, 0, 0), KIND_SUMMARY, 0, 0));
    rows.push_back(beat(ACT_LOAD, 0, 0, 16'h8000, 5));
    rows.push_back(beat(ACT_LOAD, 0, 1, 16'h8000, 5));
    rows.push_back(beat(ACT_LOAD, 1, 0, 16'h7FFF, 16'hFFFF));
    rows.push_back(beat(ACT_LOAD, 1, 1, 16'h7FFF, 16'hFFFF));
    rows.push_back(beat(ACT_LOAD, 2, 0, 16'h0000, 5));
    rows.push_back(beat(ACT_LOAD, 2, 1, 16'h0000, 5));
    rows.push_back(beat(ACT_LOAD, 10'h3FF, 8'hFF, 16'hFFFF, 16'hFFFF));
    rows.push_back(beat(ACT_UNUSED, 10'h3FF, 8'hFF, 16'hFFFF, 16'hFFFF));
    rows.push_back(beat(ACT_QUERY, 0, 0, 16'h8000, 5));
    rows.push_back(beat(ACT_QUERY, 0, 1, 16'h8000, 5));
    rows.push_back(beat(ACT_QUERY, 0, 0, 16'h7FFF, 16'hFFFF));
    rows.push_back(beat(ACT_QUERY, 0, 1, 16'h7FFF, 16'hFFFF));
    rows.push_back(beat(ACT_QUERY, 0, 0, 16'h0000, 7));
    rows.push_back(typed_beat(beat(ACT_QUERY, 0, 1, 16'h0000, 7), KIND_QUERY,
                              NO_MATCH_RANK, 3));
    // label of the last element is the one that counts
    rows.push_back(beat(ACT_QUERY, 0, 0, 16'h1234, 16'hFFFF));
    rows.push_back(beat(ACT_QUERY, 0, 1, 16'hFEDC, 5));
    rows.push_back(beat(ACT_QUERY, 0, 8'hFF, 16'h8000, 0));
    rows.push_back(beat(ACT_FINISH, 0, 0, 0, 0));
    foreach (rows[i]) send(rows[i]);

    // widest vector, one reference
    drain();
    cfg_write(CFG_FEATURE_LENGTH, 9'h1FF);
    cfg_write(CFG_REFERENCE_COUNT, 1);
    load_refs();
    full_query(ref_lab[0], 1'b0);
    send(beat(ACT_FINISH, 0, 0, 0, 0));

    // largest reference set, one element each
    drain();
    tx_idle = 25; rx_stall = 25;
    cfg_write(CFG_FEATURE_LENGTH, 0);
    cfg_write(CFG_REFERENCE_COUNT, 11'h7FF);
    load_refs();
    full_query(rnd_label(), 1'b0);
    send(beat(ACT_FINISH, 0, 0, 0, 0));

    // overfill the batch while the output is held off
    drain();
    tx_idle = 0; rx_stall = 0;
    cfg_write(CFG_FEATURE_LENGTH, 1);
    cfg_write(CFG_REFERENCE_COUNT, 0);
    load_refs();
    rx_hold = 3000;
    for (int q = 0; q < 260; q++) full_query(rnd_label(), 1'b0);
    send(beat(ACT_FINISH, 0, 0, 0, 0));

    tx_idle = 0;  rx_stall = 0;  random_phase(3, 5, 110);
    tx_idle = 74; rx_stall = 0;  random_phase(8, 12, 110);
    tx_idle = 0;  rx_stall = 74; random_phase(1, 9, 110);
    tx_idle = 25; rx_stall = 25; random_phase(5, 16, 110);
    tx_idle = 74; rx_stall = 74; random_phase(2, 1, 110);

    drain();
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
